>>> hw/rtl/jlmp_pkg.sv
// Package for the jerk-limited motion profile unit: widths, config indexes,
// controller states and the command/status structs. No dependencies.
package jlmp_pkg;

   localparam int unsigned POS_W = 32;
   localparam int unsigned VEL_W = 16;
   localparam int unsigned LIM_W = 15;
   localparam int unsigned JRK_W = 7;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned DIV_W = 32;
   localparam int unsigned DIVQ_W = DIV_W;
   localparam int unsigned DIVCNT_W = $clog2(DIV_W + 1);

   localparam logic [CSR_ADDR_W-1:0] REG_TARGET = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_VMAX   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_VMIN   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ALIM   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_JERK   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV1_START,
      ST_DIV1_WAIT,
      ST_DIV2_START,
      ST_DIV2_WAIT,
      ST_DIV3_START,
      ST_DIV3_WAIT,
      ST_ACC,
      ST_VEL,
      ST_POS,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DSEL_BRAKE1,
      DSEL_BRAKE2,
      DSEL_PIVOT
   } dsel_type;

   typedef struct packed {
      logic     load;
      logic     prep;
      logic     div_start;
      dsel_type div_sel;
      logic     acc_step;
      logic     vel_step;
      logic     pos_step;
   } ctrl_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

endpackage

>>> hw/rtl/jlmp_ctrl.sv
// Controller FSM for the motion profile unit: sequences the three divisions
// and the state updates for one tick. Depends on jlmp_pkg.
module jlmp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output jlmp_pkg::ctrl_type   ctrl,
   input  jlmp_pkg::stat_type   stat
);

   jlmp_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jlmp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jlmp_pkg::ST_IDLE:       if (req_tvalid) state_in = jlmp_pkg::ST_PREP;
         jlmp_pkg::ST_PREP:       state_in = jlmp_pkg::ST_DIV1_START;
         jlmp_pkg::ST_DIV1_START: state_in = jlmp_pkg::ST_DIV1_WAIT;
         jlmp_pkg::ST_DIV1_WAIT:  if (stat.div_done) state_in = jlmp_pkg::ST_DIV2_START;
         jlmp_pkg::ST_DIV2_START: state_in = jlmp_pkg::ST_DIV2_WAIT;
         jlmp_pkg::ST_DIV2_WAIT:  if (stat.div_done) state_in = jlmp_pkg::ST_DIV3_START;
         jlmp_pkg::ST_DIV3_START: state_in = jlmp_pkg::ST_DIV3_WAIT;
         jlmp_pkg::ST_DIV3_WAIT:  if (stat.div_done) state_in = jlmp_pkg::ST_ACC;
         jlmp_pkg::ST_ACC:        state_in = jlmp_pkg::ST_VEL;
         jlmp_pkg::ST_VEL:        state_in = jlmp_pkg::ST_POS;
         jlmp_pkg::ST_POS:        if (!rsp_valid_ff || rsp_tready) state_in = jlmp_pkg::ST_OUT;
         jlmp_pkg::ST_OUT:        state_in = jlmp_pkg::ST_IDLE;
         default:                 state_in = jlmp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.div_sel   = jlmp_pkg::DSEL_BRAKE1;
      req_tready     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         jlmp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ctrl.load  = req_tvalid;
         end
         jlmp_pkg::ST_PREP:       ctrl.prep = 1'b1;
         jlmp_pkg::ST_DIV1_START: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel   = jlmp_pkg::DSEL_BRAKE1;
         end
         jlmp_pkg::ST_DIV1_WAIT:  ctrl.div_sel = jlmp_pkg::DSEL_BRAKE1;
         jlmp_pkg::ST_DIV2_START: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel   = jlmp_pkg::DSEL_BRAKE2;
         end
         jlmp_pkg::ST_DIV2_WAIT:  ctrl.div_sel = jlmp_pkg::DSEL_BRAKE2;
         jlmp_pkg::ST_DIV3_START: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel   = jlmp_pkg::DSEL_PIVOT;
         end
         jlmp_pkg::ST_DIV3_WAIT:  ctrl.div_sel = jlmp_pkg::DSEL_PIVOT;
         jlmp_pkg::ST_ACC:        ctrl.acc_step = 1'b1;
         jlmp_pkg::ST_VEL:        ctrl.vel_step = 1'b1;
         jlmp_pkg::ST_POS:        ctrl.pos_step = !rsp_valid_ff || rsp_tready;
         jlmp_pkg::ST_OUT:        rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> hw/rtl/jlmp_datapath.sv
// Datapath for the motion profile unit: config registers, shared restoring
// divider, braking/pivot terms and the acc/vel/pos state. Depends on jlmp_pkg.
module jlmp_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [jlmp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [jlmp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [2*jlmp_pkg::VEL_W-1:0]         req_tdata,
   output logic [jlmp_pkg::POS_W+2*jlmp_pkg::VEL_W+7:0] rsp_tdata,
   input  jlmp_pkg::ctrl_type                   ctrl,
   output jlmp_pkg::stat_type                   stat
);

   localparam int unsigned DW = jlmp_pkg::DIV_W;

   logic signed [31:0] target_ff;
   logic [14:0] vmax_ff, vmin_ff, alim_ff;
   logic [6:0]  jerk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         vmax_ff   <= '0;
         vmin_ff   <= '0;
         alim_ff   <= '0;
         jerk_ff   <= 7'd1;
      end else if (csr_we) begin
         case (csr_addr)
            jlmp_pkg::REG_TARGET: target_ff <= csr_wdata[31:0];
            jlmp_pkg::REG_VMAX:   vmax_ff   <= csr_wdata[14:0];
            jlmp_pkg::REG_VMIN:   vmin_ff   <= csr_wdata[14:0];
            jlmp_pkg::REG_ALIM:   alim_ff   <= csr_wdata[14:0];
            jlmp_pkg::REG_JERK:   jerk_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   logic signed [15:0] v_ff, a_ff;
   logic [31:0] d_ff, va_ff, aa_ff, brake_ff;
   logic [15:0] vmag_ff;
   logic signed [31:0] pos_ff;
   logic signed [15:0] vel_ff, acc_ff;
   logic [7:0] jerk_eff;

   assign jerk_eff = (jerk_ff == 7'd0) ? 8'd1 : {1'b0, jerk_ff};

   logic signed [31:0] vsq, msq, dd, asq;
   logic [31:0] vaprod;
   assign vsq = v_ff * v_ff;
   assign msq = $signed({1'b0, vmin_ff}) * $signed({1'b0, vmin_ff});
   assign dd  = msq - vsq;
   assign asq = a_ff * a_ff;
   assign vaprod = vmag_ff * alim_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         v_ff <= req_tdata[15:0];
         a_ff <= req_tdata[31:16];
      end
      if (ctrl.prep) begin
         d_ff    <= dd[31] ? 32'(-dd) : 32'(dd);
         vmag_ff <= v_ff[15] ? 16'(-v_ff) : 16'(v_ff);
         aa_ff   <= asq;
      end
      if (ctrl.div_start && ctrl.div_sel == jlmp_pkg::DSEL_BRAKE1) begin
         va_ff <= vaprod;
      end
   end

   // shared restoring divider, one quotient bit per cycle
   logic [DW-1:0] q_ff, r_ff, den_ff;
   logic [jlmp_pkg::DIVCNT_W-1:0] cnt_ff;
   logic busy_ff;
   logic [DW:0] rsh;
   logic [DW-1:0] num_sel, den_sel;

   always_comb begin
      num_sel = d_ff;
      den_sel = {16'd0, alim_ff, 1'b0};
      case (ctrl.div_sel)
         jlmp_pkg::DSEL_BRAKE1: begin
            num_sel = d_ff;
            den_sel = {16'd0, alim_ff, 1'b0};
         end
         jlmp_pkg::DSEL_BRAKE2: begin
            num_sel = va_ff;
            den_sel = {23'd0, jerk_eff, 1'b0};
         end
         jlmp_pkg::DSEL_PIVOT: begin
            num_sel = aa_ff;
            den_sel = {23'd0, jerk_eff, 1'b0};
         end
         default: ;
      endcase
   end

   assign rsh = {r_ff, q_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctrl.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= jlmp_pkg::DIVCNT_W'(DW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == jlmp_pkg::DIVCNT_W'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.div_start) begin
         q_ff   <= num_sel;
         r_ff   <= '0;
         den_ff <= den_sel;
      end else if (busy_ff) begin
         if (rsh >= {1'b0, den_ff}) begin
            r_ff <= DW'(rsh - {1'b0, den_ff});
            q_ff <= {q_ff[DW-2:0], 1'b1};
         end else begin
            r_ff <= rsh[DW-1:0];
            q_ff <= {q_ff[DW-2:0], 1'b0};
         end
      end
   end

   assign stat.div_done = busy_ff && cnt_ff == jlmp_pkg::DIVCNT_W'(1);

   logic [32:0] q_fin;
   assign q_fin = {1'b0, q_ff[DW-2:0], (rsh >= {1'b0, den_ff})};

   logic [32:0] pivot_ff;
   always_ff @(posedge clock) begin
      if (stat.div_done) begin
         case (ctrl.div_sel)
            jlmp_pkg::DSEL_BRAKE1: brake_ff <= (alim_ff == '0) ? '0 : q_fin[31:0];
            jlmp_pkg::DSEL_BRAKE2: if (alim_ff != '0) brake_ff <= brake_ff + q_fin[31:0];
            jlmp_pkg::DSEL_PIVOT:  pivot_ff <= q_fin;
            default: ;
         endcase
      end
   end

   // goals
   logic signed [33:0] pos_gap;
   logic [33:0] dist_mag;
   logic below, near;
   logic signed [16:0] vgoal, agoal, verr;
   logic [16:0] verr_mag;
   assign pos_gap  = 34'(target_ff) - 34'(pos_ff);
   assign dist_mag = pos_gap[33] ? 34'(-pos_gap) : 34'(pos_gap);
   assign near     = dist_mag <= {2'b0, brake_ff};
   assign below    = target_ff < pos_ff;
   always_comb begin
      vgoal = near ? 17'(vmin_ff) : 17'(vmax_ff);
      if (below) vgoal = -vgoal;
   end
   assign verr     = vgoal - 17'(vel_ff);
   assign verr_mag = verr[16] ? 17'(-verr) : 17'(verr);
   assign agoal    = ({16'd0, verr_mag} <= pivot_ff) ? 17'sd0 : 17'(alim_ff);

   logic signed [17:0] acc_up, acc_dn, vel_up, vel_dn;
   logic signed [16:0] vgoal_ff;
   assign acc_up = 18'(acc_ff) + 18'(jerk_eff);
   assign acc_dn = 18'(acc_ff) - 18'(jerk_eff);
   assign vel_up = 18'(vel_ff) + 18'(acc_ff);
   assign vel_dn = 18'(vel_ff) - 18'(acc_ff);

   localparam logic signed [33:0] PSUM_MAX = 34'sd2147483647;
   localparam logic signed [33:0] PSUM_MIN = -34'sd2147483648;

   logic signed [33:0] psum;
   logic signed [31:0] psat;
   logic pbelow;
   assign psum   = 34'(pos_ff) + 34'(vel_ff);
   assign psat   = (psum > PSUM_MAX) ? 32'sh7FFFFFFF :
                   (psum < PSUM_MIN) ? 32'sh80000000 : psum[31:0];
   assign pbelow = pos_ff < target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vel_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (ctrl.acc_step) begin
            vgoal_ff <= vgoal;
            if (18'(acc_ff) < 18'(agoal))
               acc_ff <= (acc_up > 18'(agoal)) ? agoal[15:0] : acc_up[15:0];
            else if (18'(acc_ff) > 18'(agoal))
               acc_ff <= (acc_dn < 18'(agoal)) ? agoal[15:0] : acc_dn[15:0];
         end
         if (ctrl.vel_step) begin
            if (18'(vel_ff) < 18'(vgoal_ff))
               vel_ff <= (vel_up > 18'(vgoal_ff)) ? vgoal_ff[15:0] : vel_up[15:0];
            else if (18'(vel_ff) > 18'(vgoal_ff))
               vel_ff <= (vel_dn < 18'(vgoal_ff)) ? vgoal_ff[15:0] : vel_dn[15:0];
         end
         if (ctrl.pos_step && pos_ff != target_ff) begin
            if (pbelow)
               pos_ff <= (psum > 34'(target_ff)) ? target_ff : psat;
            else
               pos_ff <= (psum < 34'(target_ff)) ? target_ff : psat;
         end
      end
   end

   // fields low to high: cmd_position, cmd_velocity, cmd_accel, target_reached
   logic [63:0] out_ff;
   logic reached_ff;
   always_ff @(posedge clock) begin
      if (ctrl.pos_step) begin
         out_ff[31:0] <= (pos_ff != target_ff)
                         ? (pbelow ? ((psum > 34'(target_ff)) ? target_ff : psat)
                                   : ((psum < 34'(target_ff)) ? target_ff : psat))
                         : pos_ff;
         out_ff[47:32] <= vel_ff;
         out_ff[63:48] <= acc_ff;
         reached_ff    <= (pos_ff == target_ff) ||
                          (pbelow ? (psum >= 34'(target_ff)) : (psum <= 34'(target_ff)));
      end
   end

   assign rsp_tdata = {7'd0, reached_ff, out_ff};

endmodule

>>> hw/rtl/jerk_limited_motion_profile_unit.sv
// Top level of the jerk-limited S-curve motion profile unit.
// Joins jlmp_ctrl and jlmp_datapath. Depends on jlmp_pkg.
//
// One servo tick per request beat: the block takes a beat, runs three
// divisions on one shared restoring divider, then updates acceleration,
// velocity and position. The next request beat can be taken in the same
// cycle as the result beat becomes valid. A result beat still waiting at
// the position update holds the tick there until it is taken. Config must
// be written only while no tick is in flight; the block itself does not
// enforce this.
module jerk_limited_motion_profile_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [jlmp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [jlmp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // measured_velocity, measured_accel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [71:0]                       rsp_tdata   // cmd_position, cmd_velocity,
                                                         // cmd_accel, target_reached
);

   jlmp_pkg::ctrl_type ctrl;
   jlmp_pkg::stat_type stat;

   jlmp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .ctrl(ctrl), .stat(stat)
   );

   jlmp_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tdata(req_tdata), .rsp_tdata(rsp_tdata),
      .ctrl(ctrl), .stat(stat)
   );

endmodule

>>> hw/rtl/jlmp_checker.sv
// Port-level checker for the motion profile unit, bound to the top level.
// Depends on jerk_limited_motion_profile_unit.
module jlmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("beat taken during a tick");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:65] == 7'd0)
      else $error("rsp pad bits not zero");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind jerk_limited_motion_profile_unit jlmp_checker u_jlmp_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
